/* hw/rtl/pps_pkg.sv */
package pps_pkg;

  // Field widths
  localparam int FREQ_W = 32;
  localparam int CLK_W  = 32;
  localparam int DUTY_W = 17;
  localparam int CNT_W  = 32;
  localparam int CODE_W = 4;
  localparam int STAT_W = 2;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;

  // Prescaler scan: dividers 1 .. 2**(NUM_PRESCALERS-1)
  localparam int NUM_PRESCALERS = 14;
  localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(NUM_PRESCALERS - 1);

  // Divider datapath: denominator is frequency shifted by the code
  localparam int DEN_W  = FREQ_W + NUM_PRESCALERS - 1;
  localparam int NUM_W  = DEN_W + 1;
  localparam int STEP_W = $clog2(NUM_W);

  // Duty product: period * duty + half, then >> 16
  localparam int FRAC_W = 16;
  localparam int PROD_W = CNT_W + DUTY_W + 1;
  localparam int T_W    = PROD_W - FRAC_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32'h8000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL     = 1'b1;
  localparam logic [CLK_W-1:0]     CLOCK_HZ_RST = 32'd100000000;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Output modes
  localparam logic [MODE_W-1:0] MODE_COMPARE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOW     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIGH    = 2'd2;

  typedef logic [DEN_W-1:0]  den_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [PROD_W-1:0] prod_t;

  // Divider request and response
  typedef struct packed {
    logic start;
    num_t numer;
    den_t denom;
  } div_req_t;

  typedef struct packed {
    logic done;
    num_t quot;
    den_t rem;
  } div_rsp_t;

endpackage

/* hw/rtl/pps_div.sv */
module pps_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pps_pkg::div_req_t req,
  output pps_pkg::div_rsp_t rsp
);

  logic               busy_r;
  logic               done_r;
  pps_pkg::step_t     step_r;
  pps_pkg::den_t      den_r;
  pps_pkg::den_t      rem_r;
  pps_pkg::num_t      quo_r;

  logic [pps_pkg::DEN_W:0]   acc;
  logic [pps_pkg::DEN_W+1:0] diff;
  logic                      q_bit;

  // One restoring step: shift in the next numerator bit, try subtract
  always_comb begin
    acc   = {rem_r, quo_r[pps_pkg::NUM_W-1]};
    diff  = {1'b0, acc} - {2'b00, den_r};
    q_bit = ~diff[pps_pkg::DEN_W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= pps_pkg::step_t'(pps_pkg::NUM_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // Datapath: numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.numer;
      den_r <= req.denom;
    end else if (busy_r) begin
      rem_r <= q_bit ? diff[pps_pkg::DEN_W-1:0] : acc[pps_pkg::DEN_W-1:0];
      quo_r <= {quo_r[pps_pkg::NUM_W-2:0], q_bit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

/* hw/rtl/pwm_prescaler_period_duty_solver_core.sv */
// Zero or out-of-range frequency gives its result in the cycle after acceptance.
// Otherwise each prescaler tried takes a launch, 46 restoring divider steps and a
// compare; the duty multiplies and the result follow the scan.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// The bit-serial divider sets the length of a transaction. The receiver cannot stall the result.
// Reset: synchronous active-low; clock_hz returns to 100000000, dual_output to 0.
module pwm_prescaler_period_duty_solver_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic [pps_pkg::FREQ_W-1:0]          in_frequency,
  input  logic [pps_pkg::DUTY_W-1:0]          in_duty_a,
  input  logic [pps_pkg::DUTY_W-1:0]          in_duty_b,
  // result channel
  output logic                                out_valid,
  output logic [pps_pkg::STAT_W-1:0]          out_status,
  output logic [pps_pkg::CODE_W-1:0]          out_prescale_code,
  output logic [pps_pkg::CNT_W-1:0]           out_period_count,
  output logic [pps_pkg::CNT_W-1:0]           out_period_reg,
  output logic [pps_pkg::CNT_W-1:0]           out_duty_count_a,
  output logic [pps_pkg::CNT_W-1:0]           out_duty_count_b,
  output logic [pps_pkg::CNT_W-1:0]           out_compare_a,
  output logic [pps_pkg::CNT_W-1:0]           out_compare_b,
  output logic [pps_pkg::MODE_W-1:0]          out_duty_mode_a,
  output logic [pps_pkg::MODE_W-1:0]          out_duty_mode_b,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pps_pkg::CFG_DAT_W-1:0]       cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LAUNCH = 6'b000010,
    S_DIV    = 6'b000100,
    S_MULA   = 6'b001000,
    S_MULB   = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [pps_pkg::CLK_W-1:0] clock_hz_r;
  logic                      dual_r;

  // latched item and scan state
  logic [pps_pkg::FREQ_W-1:0] freq_r;
  logic [pps_pkg::DUTY_W-1:0] duty_a_r;
  logic [pps_pkg::DUTY_W-1:0] duty_b_r;
  logic [pps_pkg::CODE_W-1:0] idx_r;
  pps_pkg::den_t              denom_r;
  logic                       best_valid_r;
  pps_pkg::den_t              best_err_r;
  logic [pps_pkg::CNT_W-1:0]  pick_period_r;
  logic [pps_pkg::CODE_W-1:0] best_code_r;
  logic [pps_pkg::T_W-1:0]    ta_r;
  logic [pps_pkg::T_W-1:0]    tb_r;

  // result registers
  logic                       out_valid_r;
  logic [pps_pkg::STAT_W-1:0] status_r;
  logic [pps_pkg::CODE_W-1:0] code_r;
  logic [pps_pkg::CNT_W-1:0]  period_r;
  logic [pps_pkg::CNT_W-1:0]  period_reg_r;
  logic [pps_pkg::CNT_W-1:0]  cnt_a_r;
  logic [pps_pkg::CNT_W-1:0]  cnt_b_r;
  logic [pps_pkg::CNT_W-1:0]  cmp_a_r;
  logic [pps_pkg::CNT_W-1:0]  cmp_b_r;
  logic [pps_pkg::MODE_W-1:0] mode_a_r;
  logic [pps_pkg::MODE_W-1:0] mode_b_r;

  pps_pkg::div_req_t div_req;
  pps_pkg::div_rsp_t div_rsp;

  logic                       accept;
  logic                       freq_zero;
  logic                       freq_high;
  pps_pkg::den_t              denom_w;
  pps_pkg::den_t              half_w;
  pps_pkg::den_t              err_w;
  logic                       fits_w;
  logic                       better_w;
  logic [pps_pkg::DUTY_W-1:0] mul_duty;
  pps_pkg::prod_t             prod_w;
  logic [pps_pkg::CNT_W-1:0]  ca_w;
  logic [pps_pkg::CNT_W-1:0]  cb_w;
  logic [pps_pkg::CNT_W-1:0]  cmpa_w;
  logic [pps_pkg::CNT_W-1:0]  cmpb_w;
  logic [pps_pkg::MODE_W-1:0] ma_w;
  logic [pps_pkg::MODE_W-1:0] mb_w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign freq_zero = (in_frequency == '0);
  assign freq_high = (in_frequency > (clock_hz_r >> 1));

  // divider launch: denom = freq << code, numer = clk + denom/2
  always_comb begin
    denom_w       = {{(pps_pkg::DEN_W - pps_pkg::FREQ_W){1'b0}}, freq_r} << idx_r;
    div_req.start = (state_r == S_LAUNCH);
    div_req.denom = denom_w;
    div_req.numer = {{(pps_pkg::NUM_W - pps_pkg::CLK_W){1'b0}}, clock_hz_r}
                  + {1'b0, denom_w >> 1};
  end

  pps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // period error from the remainder: |rem - denom/2|
  always_comb begin
    half_w   = denom_r >> 1;
    err_w    = (div_rsp.rem >= half_w) ? (div_rsp.rem - half_w) : (half_w - div_rsp.rem);
    fits_w   = (div_rsp.quot != '0) && (div_rsp.quot[pps_pkg::NUM_W-1:pps_pkg::CNT_W] == '0);
    better_w = fits_w && (!best_valid_r || (err_w < best_err_r));
  end

  // shared duty multiplier
  always_comb begin
    mul_duty = (state_r == S_MULA) ? duty_a_r : duty_b_r;
    prod_w   = pps_pkg::prod_t'(pick_period_r) * pps_pkg::prod_t'(mul_duty)
             + pps_pkg::ROUND_HALF;
  end

  // clamp, compare values and modes
  always_comb begin
    ca_w   = (ta_r >= pps_pkg::T_W'(pick_period_r)) ? (pick_period_r - 1'b1)
                                                    : ta_r[pps_pkg::CNT_W-1:0];
    cb_w   = (tb_r >= pps_pkg::T_W'(pick_period_r)) ? (pick_period_r - 1'b1)
                                                    : tb_r[pps_pkg::CNT_W-1:0];
    cmpa_w = (ca_w != '0) ? (ca_w - 1'b1) : '0;
    cmpb_w = (cb_w != '0) ? (cb_w - 1'b1) : '0;
    if (ca_w == '0)                 ma_w = pps_pkg::MODE_LOW;
    else if (ca_w >= pick_period_r) ma_w = pps_pkg::MODE_HIGH;
    else                            ma_w = pps_pkg::MODE_COMPARE;
    if (cb_w == '0)                 mb_w = pps_pkg::MODE_LOW;
    else if (cb_w >= pick_period_r) mb_w = pps_pkg::MODE_HIGH;
    else                            mb_w = pps_pkg::MODE_COMPARE;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= pps_pkg::CLOCK_HZ_RST;
      dual_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pps_pkg::REG_CLOCK_HZ: clock_hz_r <= cfg_data;
        pps_pkg::REG_DUAL:     dual_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      best_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (freq_zero || freq_high) begin
              out_valid_r <= 1'b1;
            end else begin
              idx_r        <= '0;
              best_valid_r <= 1'b0;
              state_r      <= S_LAUNCH;
            end
          end
        end
        S_LAUNCH: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (better_w) begin
              best_valid_r <= 1'b1;
            end
            if (better_w && (err_w == '0)) begin
              state_r <= S_MULA;
            end else if (idx_r == pps_pkg::LAST_CODE) begin
              if (best_valid_r || better_w) begin
                state_r <= S_MULA;
              end else begin
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_LAUNCH;
            end
          end
        end
        S_MULA: begin
          state_r <= S_MULB;
        end
        S_MULB: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          freq_r   <= in_frequency;
          duty_a_r <= in_duty_a;
          duty_b_r <= in_duty_b;
          status_r <= freq_zero ? pps_pkg::ST_ZERO : pps_pkg::ST_RANGE;
          code_r       <= '0;
          period_r     <= '0;
          period_reg_r <= '0;
          cnt_a_r      <= '0;
          cnt_b_r      <= '0;
          cmp_a_r      <= '0;
          cmp_b_r      <= '0;
          mode_a_r     <= '0;
          mode_b_r     <= '0;
        end
      end
      S_LAUNCH: begin
        denom_r <= denom_w;
      end
      S_DIV: begin
        if (div_rsp.done && better_w) begin
          best_err_r    <= err_w;
          pick_period_r <= div_rsp.quot[pps_pkg::CNT_W-1:0];
          best_code_r   <= idx_r;
        end
      end
      S_MULA: begin
        ta_r <= prod_w[pps_pkg::PROD_W-1:pps_pkg::FRAC_W];
      end
      S_MULB: begin
        tb_r <= prod_w[pps_pkg::PROD_W-1:pps_pkg::FRAC_W];
      end
      S_FIN: begin
        status_r     <= pps_pkg::ST_OK;
        code_r       <= best_code_r;
        period_r     <= pick_period_r;
        period_reg_r <= pick_period_r - 1'b1;
        cnt_a_r      <= ca_w;
        cmp_a_r      <= cmpa_w;
        mode_a_r     <= ma_w;
        cnt_b_r      <= dual_r ? cb_w : '0;
        cmp_b_r      <= dual_r ? cmpb_w : cmpa_w;
        mode_b_r     <= dual_r ? mb_w : pps_pkg::MODE_LOW;
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_prescale_code = code_r;
  assign out_period_count  = period_r;
  assign out_period_reg    = period_reg_r;
  assign out_duty_count_a  = cnt_a_r;
  assign out_duty_count_b  = cnt_b_r;
  assign out_compare_a     = cmp_a_r;
  assign out_compare_b     = cmp_b_r;
  assign out_duty_mode_a   = mode_a_r;
  assign out_duty_mode_b   = mode_b_r;

endmodule

/* hw/rtl/pps_chk.sv */
module pps_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [pps_pkg::STAT_W-1:0]    out_status,
  input logic [pps_pkg::CNT_W-1:0]     out_period_count,
  input logic [pps_pkg::CNT_W-1:0]     out_period_reg,
  input logic [pps_pkg::CNT_W-1:0]     out_duty_count_a,
  input logic [pps_pkg::MODE_W-1:0]    out_duty_mode_a
);

  // an accepted transaction either finishes at once or holds busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither busy nor finished");

  // busy drops only together with the result strobe
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // error results carry zero period and duty
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pps_pkg::ST_OK) |->
      (out_period_count == '0 && out_duty_count_a == '0))
    else $error("error result with nonzero fields");

  // good results: period register and clamped duty
  a_ok_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == pps_pkg::ST_OK) |->
      (out_period_count != '0 && out_period_reg == out_period_count - 1'b1
       && out_duty_count_a < out_period_count
       && out_duty_mode_a != pps_pkg::MODE_HIGH))
    else $error("period or duty inconsistent");

endmodule

bind pwm_prescaler_period_duty_solver_core pps_chk u_pps_chk (.*);

/* sim/pwm_prescaler_period_duty_solver_core_test.sv */
module pwm_prescaler_period_duty_solver_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;

  // One requested PWM setup; hold_off makes the driver wait for all results first
  typedef struct packed {
    logic [pps_pkg::FREQ_W-1:0] freq;
    logic [pps_pkg::DUTY_W-1:0] duty_a;
    logic [pps_pkg::DUTY_W-1:0] duty_b;
    logic                       hold_off;
  } pwm_request_t;

  // Solved timer setup, one per request
  typedef struct packed {
    logic [pps_pkg::STAT_W-1:0] status;
    logic [pps_pkg::CODE_W-1:0] code;
    logic [pps_pkg::CNT_W-1:0]  period;
    logic [pps_pkg::CNT_W-1:0]  period_reg;
    logic [pps_pkg::CNT_W-1:0]  count_a;
    logic [pps_pkg::CNT_W-1:0]  count_b;
    logic [pps_pkg::CNT_W-1:0]  cmp_a;
    logic [pps_pkg::CNT_W-1:0]  cmp_b;
    logic [pps_pkg::MODE_W-1:0] mode_a;
    logic [pps_pkg::MODE_W-1:0] mode_b;
  } pwm_setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [pps_pkg::FREQ_W-1:0] in_frequency = '0;
  logic [pps_pkg::DUTY_W-1:0] in_duty_a = '0;
  logic [pps_pkg::DUTY_W-1:0] in_duty_b = '0;
  logic out_valid;
  logic [pps_pkg::STAT_W-1:0] out_status;
  logic [pps_pkg::CODE_W-1:0] out_prescale_code;
  logic [pps_pkg::CNT_W-1:0] out_period_count;
  logic [pps_pkg::CNT_W-1:0] out_period_reg;
  logic [pps_pkg::CNT_W-1:0] out_duty_count_a;
  logic [pps_pkg::CNT_W-1:0] out_duty_count_b;
  logic [pps_pkg::CNT_W-1:0] out_compare_a;
  logic [pps_pkg::CNT_W-1:0] out_compare_b;
  logic [pps_pkg::MODE_W-1:0] out_duty_mode_a;
  logic [pps_pkg::MODE_W-1:0] out_duty_mode_b;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pps_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  // Local copy of the configuration registers
  logic [pps_pkg::CLK_W-1:0] clock_hz_m = pps_pkg::CLOCK_HZ_RST;
  logic                      dual_m = 1'b0;

  pwm_request_t request_q[$];
  pwm_setting_t setting_q[$];
  int  items_taken = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  gap_left = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;
  bit  took;
  pwm_request_t next_req;
  pwm_setting_t want;

  pwm_prescaler_period_duty_solver_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_frequency      (in_frequency),
    .in_duty_a         (in_duty_a),
    .in_duty_b         (in_duty_b),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_prescale_code (out_prescale_code),
    .out_period_count  (out_period_count),
    .out_period_reg    (out_period_reg),
    .out_duty_count_a  (out_duty_count_a),
    .out_duty_count_b  (out_duty_count_b),
    .out_compare_a     (out_compare_a),
    .out_compare_b     (out_compare_b),
    .out_duty_mode_a   (out_duty_mode_a),
    .out_duty_mode_b   (out_duty_mode_b),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Rounded high-time counts, held below the period
  function automatic logic [pps_pkg::CNT_W-1:0] high_counts(
      logic [pps_pkg::CNT_W-1:0] period, logic [pps_pkg::DUTY_W-1:0] duty);
    logic [63:0] t;
    t = ({32'd0, period} * {47'd0, duty} + 64'h8000) >> pps_pkg::FRAC_W;
    if (t >= {32'd0, period}) return (period != 0) ? period - 1 : '0;
    return t[pps_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [pps_pkg::MODE_W-1:0] duty_mode(
      logic [pps_pkg::CNT_W-1:0] counts, logic [pps_pkg::CNT_W-1:0] period);
    if (period == 0 || counts == 0) return pps_pkg::MODE_LOW;
    if (counts >= period) return pps_pkg::MODE_HIGH;
    return pps_pkg::MODE_COMPARE;
  endfunction

  // Prescaler scan and duty conversion for one request
  function automatic pwm_setting_t solve_setting(logic [pps_pkg::FREQ_W-1:0] freq,
                                                 logic [pps_pkg::DUTY_W-1:0] duty_a,
                                                 logic [pps_pkg::DUTY_W-1:0] duty_b,
                                                 logic [pps_pkg::CLK_W-1:0] clk_hz,
                                                 logic dual);
    pwm_setting_t s;
    logic [63:0] clk64, den, cnt, actual, err, best_err;
    logic [pps_pkg::CNT_W-1:0] chosen_period;
    logic [pps_pkg::CODE_W-1:0] best_code;
    int i;
    bit exact;
    s = '0;
    clk64 = {32'd0, clk_hz};
    if (freq == 0) begin
      s.status = pps_pkg::ST_ZERO;
    end else if ({32'd0, freq} > clk64 / 2) begin
      s.status = pps_pkg::ST_RANGE;
    end else begin
      best_err = '1;
      chosen_period = '0;
      best_code = '0;
      exact = 1'b0;
      for (i = 0; i < pps_pkg::NUM_PRESCALERS && !exact; i++) begin
        den = {32'd0, freq} << i;
        cnt = (clk64 + den / 2) / den;
        if (cnt != 0 && cnt <= 64'hFFFF_FFFF) begin
          actual = cnt * den;
          err = (clk64 > actual) ? clk64 - actual : actual - clk64;
          if (err < best_err) begin
            best_err = err;
            chosen_period = cnt[pps_pkg::CNT_W-1:0];
            best_code = pps_pkg::CODE_W'(i);
            exact = (err == 0);
          end
        end
      end
      if (chosen_period == 0) begin
        s.status = pps_pkg::ST_RANGE;
      end else begin
        s.status = pps_pkg::ST_OK;
        s.code = best_code;
        s.period = chosen_period;
        s.period_reg = chosen_period - 1;
        s.count_a = high_counts(chosen_period, duty_a);
        s.cmp_a = (s.count_a != 0) ? s.count_a - 1 : '0;
        s.mode_a = duty_mode(s.count_a, chosen_period);
        if (dual) begin
          s.count_b = high_counts(chosen_period, duty_b);
          s.cmp_b = (s.count_b != 0) ? s.count_b - 1 : '0;
          s.mode_b = duty_mode(s.count_b, chosen_period);
        end else begin
          s.count_b = '0;
          s.cmp_b = s.cmp_a;
          s.mode_b = pps_pkg::MODE_LOW;
        end
      end
    end
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, exp_val));
  endtask

  // Driver: present pending requests, record the expected setup on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        setting_q.push_back(solve_setting(in_frequency, in_duty_a, in_duty_b,
                                          clock_hz_m, dual_m));
        items_taken++;
        gap_left = no_gaps ? 0 : $urandom_range(0, 4);
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      if ((took || !start) && gap_left == 0 && request_q.size() != 0 &&
          (!request_q[0].hold_off || (!took && items_taken == results_seen))) begin
        next_req = request_q.pop_front();
        start <= 1'b1;
        in_frequency <= next_req.freq;
        in_duty_a <= next_req.duty_a;
        in_duty_b <= next_req.duty_b;
      end else if (took) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (setting_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request pending", results_seen));
      end else begin
        want = setting_q.pop_front();
        check_field("status", out_status, want.status);
        check_field("prescale_code", out_prescale_code, want.code);
        check_field("period_count", out_period_count, want.period);
        check_field("period_reg", out_period_reg, want.period_reg);
        check_field("duty_count_a", out_duty_count_a, want.count_a);
        check_field("duty_count_b", out_duty_count_b, want.count_b);
        check_field("compare_a", out_compare_a, want.cmp_a);
        check_field("compare_b", out_compare_b, want.cmp_b);
        check_field("duty_mode_a", out_duty_mode_a, want.mode_a);
        check_field("duty_mode_b", out_duty_mode_b, want.mode_b);
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic queue_item(logic [pps_pkg::FREQ_W-1:0] freq,
                            logic [pps_pkg::DUTY_W-1:0] da,
                            logic [pps_pkg::DUTY_W-1:0] db, logic hold = 1'b0);
    request_q.push_back('{freq: freq, duty_a: da, duty_b: db, hold_off: hold});
  endtask

  // Settled at the falling edge, so no race with the clocked blocks
  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || start || items_taken != results_seen);
  endtask

  task automatic write_reg(logic [pps_pkg::CFG_IDX_W-1:0] idx,
                           logic [pps_pkg::CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == pps_pkg::REG_CLOCK_HZ) clock_hz_m = data;
    else dual_m = data[0];
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [pps_pkg::DUTY_W-1:0] random_duty();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'h10000;
      2: return 17'h1FFFF;
      3: return pps_pkg::DUTY_W'($urandom_range(0, 3));
      4: return pps_pkg::DUTY_W'($urandom);
      default: return pps_pkg::DUTY_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Stimulus
  initial begin
    int ph, n, sel;
    logic [pps_pkg::CLK_W-1:0] clk_sel;
    logic [63:0] span, den;
    logic [pps_pkg::FREQ_W-1:0] f;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: zero, out of range, the half-clock edge, clamp, exact fit
    queue_item(32'd0, 17'd0, 17'd0);
    queue_item(32'hFFFF_FFFF, 17'h10000, 17'h10000);
    queue_item(32'd50000000, 17'h10000, 17'd0);
    queue_item(32'd50000001, 17'h08000, 17'h08000);
    queue_item(32'd1, 17'h1FFFF, 17'h1FFFF);
    queue_item(32'd100000, 17'h08000, 17'h04000);
    queue_item(32'd1000, 17'd1, 17'd1);
    queue_item(32'd7, 17'h0FFFF, 17'd2);
    queue_item(32'd3, 17'd0, 17'h1FFFF);

    // Second output in use
    wait_idle();
    write_reg(pps_pkg::REG_DUAL, 32'd1);
    queue_item(32'd20000, 17'h10000, 17'd0);
    queue_item(32'd33333, 17'h1FFFF, 17'd1);
    queue_item(32'd1, 17'h08000, 17'h1FFFF);
    queue_item(32'd49999999, 17'h0FFFF, 17'h08000, 1'b1);
    queue_item(32'd0, 17'h1FFFF, 17'h1FFFF);
    queue_item(32'd12345, 17'd1, 17'h10000);

    // Largest clock
    wait_idle();
    write_reg(pps_pkg::REG_CLOCK_HZ, 32'hFFFF_FFFF);
    queue_item(32'd1, 17'h10000, 17'd1);
    queue_item(32'h7FFF_FFFF, 17'h08000, 17'h1FFFF);
    queue_item(32'h8000_0000, 17'h08000, 17'h08000);
    queue_item(32'd3, 17'h05555, 17'h0AAAA);

    // Smallest clocks
    wait_idle();
    write_reg(pps_pkg::REG_CLOCK_HZ, 32'd1);
    queue_item(32'd1, 17'h08000, 17'h08000);
    queue_item(32'd0, 17'd0, 17'd0);
    wait_idle();
    write_reg(pps_pkg::REG_CLOCK_HZ, 32'd2);
    write_reg(pps_pkg::REG_DUAL, 32'd0);
    queue_item(32'd1, 17'h08000, 17'h1FFFF);

    // Random phases over several clock settings
    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: clk_sel = 32'd100000000;
        1: clk_sel = 32'hFFFF_FFFF;
        2: clk_sel = 32'd1;
        3: clk_sel = 32'd3;
        4: clk_sel = 32'd48000000;
        default: clk_sel = $urandom;
      endcase
      if (clk_sel == 0) clk_sel = 32'd1;
      write_reg(pps_pkg::REG_CLOCK_HZ, clk_sel);
      write_reg(pps_pkg::REG_DUAL, {31'd0, ph[0]});
      no_gaps = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 70; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          f = '0;
        end else if (sel < 15) begin
          f = $urandom;
        end else if (sel < 20) begin
          f = clk_sel / 2 + $urandom_range(0, 1);
        end else if (sel < 32) begin
          f = $urandom_range(1, 2000);
        end else if (sel < 42) begin
          // often an exact fit at a small divider
          f = clk_sel >> $urandom_range(1, 20);
        end else begin
          span = 64'd1 << $urandom_range(1, 44);
          den = span | ({$urandom, $urandom} & (span - 1));
          f = pps_pkg::FREQ_W'({32'd0, clk_sel} / den);
        end
        if (sel >= 5 && f == 0) f = 32'd1;
        queue_item(f, random_duty(), random_duty(), $urandom_range(0, 99) < 3);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
